// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files.
// Depends on nothing; each macro takes a label, a property body and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion, disabled while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assertion that also checks during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ----- hw/rtl/pwl_pkg.sv -----
// Package for the piecewise-linear waveform lookup.
// Holds sizes, status codes and register indexes; depends on nothing.
package pwl_pkg;
  localparam int Depth    = 1024;
  localparam int AddrBits = $clog2(Depth);
  localparam int CntBits  = 11;
  localparam int TimeBits = 32;
  localparam int ValBits  = 32;
  localparam int FracBits = 16;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_BEFORE = 3'd1,
    ST_AFTER  = 3'd2,
    ST_NREADY = 3'd3,
    ST_ORDER  = 3'd4,
    ST_FULL   = 3'd5
  } status_t;

  localparam logic CFG_HOLD  = 1'b0;
  localparam logic CFG_COUNT = 1'b1;
  localparam logic KIND_LOAD = 1'b0;
endpackage

// ----- hw/rtl/piecewise_linear_waveform_lookup.sv -----
// Piecewise-linear waveform lookup, top level.
// Uses pwl_pkg and assert_macros.svh; holds both breakpoint memories.
//
// A load request, and a query answered with the not-ready status, has its
// result registered in the cycle after acceptance. A query answered at an end
// of the table or with an out-of-range status goes through S_ENDS, S_ENDS_W
// and S_DONE; one that interpolates adds S_SRCH/S_SRCH_W, S_FETCH/S_FETCH_W,
// S_DIV, S_MUL and S_ROUND: the binary search does one registered memory read
// per step, and the weight comes from a restoring divider that yields one
// quotient bit per cycle. One request is worked on at a time; the output
// register frees the input side as soon as the result is written to it, so
// the next request waits only while the result itself is stalled.
`include "assert_macros.svh"
module piecewise_linear_waveform_lookup import pwl_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_kind,
  input  logic [TimeBits-1:0]        in_time_point,
  input  logic signed [ValBits-1:0]  in_sample_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [ValBits-1:0]  out_result_value,
  output logic [2:0]                 out_status,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [CntBits-1:0]         cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_ENDS, S_ENDS_W, S_SRCH, S_SRCH_W, S_FETCH, S_FETCH_W,
    S_DIV, S_MUL, S_ROUND, S_DONE
  } state_t;

  // Breakpoint memories, one write and one registered read port each.
  logic [TimeBits-1:0] time_mem [Depth];
  logic [ValBits-1:0]  val_mem  [Depth];
  logic [AddrBits-1:0] rd_addr;
  logic [TimeBits-1:0] rd_time_r;
  logic [ValBits-1:0]  rd_val_r;
  logic                wr_en;
  logic [AddrBits-1:0] wr_addr;

  state_t              state_r;
  logic                hold_r;
  logic [CntBits-1:0]  count_r;
  logic [CntBits-1:0]  loaded_r;
  logic [TimeBits-1:0] last_r;
  logic [TimeBits-1:0] qt_r;
  logic [CntBits-1:0]  lo_r, hi_r;
  logic [TimeBits-1:0] t0_r, d_r;
  logic [ValBits-1:0]  v0_r;
  logic [TimeBits:0]   rem_r;
  logic [FracBits:0]   w_r;
  logic [5:0]          step_r;
  logic                neg_r;
  logic [ValBits:0]    mag_r;
  logic [ValBits+FracBits+1:0] prod_r;
  logic                out_valid_r;
  logic [ValBits-1:0]  out_val_r;
  logic [2:0]          out_st_r;

  logic in_acc, out_acc, busy;
  logic [CntBits-1:0] mid;
  logic [TimeBits+1:0] rem_sh;
  logic [ValBits:0] diff;
  logic [CntBits-1:0] cnt_clamp;

  assign busy      = (state_r != S_IDLE);
  assign in_stall  = busy || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_result_value = out_val_r;
  assign out_status       = out_st_r;

  assign mid    = lo_r + ((hi_r - lo_r) >> 1);
  assign rem_sh = {rem_r, 1'b0};
  assign diff   = {rd_val_r[ValBits-1], rd_val_r} - {v0_r[ValBits-1], v0_r};

  // Clamp of the count register write.
  always_comb begin
    cnt_clamp = cfg_data;
    if (cfg_data < CntBits'(2)) cnt_clamp = CntBits'(2);
    else if (cfg_data > CntBits'(Depth)) cnt_clamp = CntBits'(Depth);
  end

  // Memory write on a successful load request.
  assign wr_en   = in_acc && (in_kind == KIND_LOAD) && (loaded_r < count_r) &&
                   (loaded_r == '0 || in_time_point > last_r);
  assign wr_addr = loaded_r[AddrBits-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[wr_addr] <= in_time_point;
      val_mem[wr_addr]  <= in_sample_value;
    end
    rd_time_r <= time_mem[rd_addr];
    rd_val_r  <= val_mem[rd_addr];
  end

  // Read address per state.
  always_comb begin
    rd_addr = '0;
    unique case (state_r)
      S_ENDS:  rd_addr = AddrBits'(count_r - CntBits'(1));
      S_SRCH:  rd_addr = mid[AddrBits-1:0];
      S_FETCH: rd_addr = AddrBits'(lo_r - CntBits'(1));
      S_FETCH_W: rd_addr = lo_r[AddrBits-1:0];
      default: rd_addr = '0;
    endcase
  end

  // Sequencer, registers and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hold_r      <= 1'b1;
      count_r     <= CntBits'(2);
      loaded_r    <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_acc) out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_HOLD) hold_r <= cfg_data[0];
        else begin
          count_r  <= cnt_clamp;
          loaded_r <= '0;
          last_r   <= '0;
        end
      end
      unique case (state_r)
        S_IDLE: if (in_acc) begin
          qt_r <= in_time_point;
          if (in_kind == KIND_LOAD) begin
            out_valid_r <= 1'b1;
            out_val_r   <= '0;
            if (loaded_r >= count_r) out_st_r <= ST_FULL;
            else if (loaded_r != '0 && in_time_point <= last_r) out_st_r <= ST_ORDER;
            else begin
              out_st_r <= ST_OK;
              loaded_r <= loaded_r + CntBits'(1);
              last_r   <= in_time_point;
            end
          end else if (loaded_r < count_r) begin
            out_valid_r <= 1'b1;
            out_val_r   <= '0;
            out_st_r    <= ST_NREADY;
          end else begin
            state_r <= S_ENDS;
          end
        end
        // The address 0 read has landed and is captured; this state reads the last entry.
        S_ENDS: begin
          t0_r    <= rd_time_r;
          v0_r    <= rd_val_r;
          state_r <= S_ENDS_W;
        end
        S_ENDS_W: begin
          state_r <= S_DONE;
          out_st_r  <= ST_OK;
          out_val_r <= '0;
          if (qt_r < t0_r || qt_r == t0_r) begin
            if (qt_r == t0_r || hold_r) out_val_r <= v0_r;
            else out_st_r <= ST_BEFORE;
          end else if (qt_r > rd_time_r || qt_r == rd_time_r) begin
            if (qt_r == rd_time_r || hold_r) out_val_r <= rd_val_r;
            else out_st_r <= ST_AFTER;
          end else begin
            lo_r    <= CntBits'(1);
            hi_r    <= count_r - CntBits'(1);
            state_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (lo_r >= hi_r) state_r <= S_FETCH;
          else state_r <= S_SRCH_W;
        end
        S_SRCH_W: begin
          if (rd_time_r > qt_r) hi_r <= mid;
          else lo_r <= mid + CntBits'(1);
          state_r <= S_SRCH;
        end
        S_FETCH: state_r <= S_FETCH_W;
        S_FETCH_W: begin
          t0_r    <= rd_time_r;
          v0_r    <= rd_val_r;
          state_r <= S_DIV;
          step_r  <= '0;
        end
        // First DIV cycle captures the upper entry; then one bit a cycle.
        S_DIV: begin
          if (step_r == '0) begin
            d_r    <= rd_time_r - t0_r;
            rem_r  <= {1'b0, qt_r - t0_r};
            w_r    <= '0;
            neg_r  <= diff[ValBits];
            mag_r  <= diff[ValBits] ? -diff : diff;
            step_r <= 6'd1;
          end else if (step_r <= 6'(FracBits)) begin
            if (rem_sh >= {2'b0, d_r}) begin
              rem_r <= (TimeBits+1)'(rem_sh - {2'b0, d_r});
              w_r   <= {w_r[FracBits-1:0], 1'b1};
            end else begin
              rem_r <= rem_sh[TimeBits:0];
              w_r   <= {w_r[FracBits-1:0], 1'b0};
            end
            step_r <= step_r + 6'd1;
          end else begin
            if (rem_sh >= {2'b0, d_r}) w_r <= w_r + (FracBits+1)'(1);
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= (ValBits+FracBits+2)'(mag_r * w_r);
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          out_val_r <= neg_r ?
            v0_r - ValBits'((prod_r >> FracBits) +
                            (ValBits+FracBits+2)'(prod_r[FracBits-1])) :
            v0_r + ValBits'((prod_r >> FracBits) +
                            (ValBits+FracBits+2)'(prod_r[FracBits-1]));
          out_st_r <= ST_OK;
          state_r  <= S_DONE;
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_no_accept_busy, busy |-> !in_acc, "request accepted while busy")
  `ASSERT_CLK(a_loaded_bound, loaded_r <= count_r, "table fill exceeds count")
  `ASSERT_CLK(a_status_range, out_valid_r |-> (out_st_r <= ST_FULL), "bad status")
  `ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r),
    "not idle after reset")
endmodule
